// File: design/mfsp_pkg.sv
package mfsp_pkg;

    // motor slots and bus identifiers
    localparam int MOTOR_COUNT = 4;
    localparam int SLOT_COUNT  = 4;
    localparam logic [10:0] ID_BASE = 11'h201;
    localparam logic [10:0] ID_END  = ID_BASE + 11'(MOTOR_COUNT);

    // rotor angle wrap handling
    localparam logic signed [14:0] HALF_TURN = 15'sd4096;
    localparam logic signed [14:0] FULL_TURN = 15'sd8192;

    // pid datapath
    localparam int GAIN_FRACTION_BITS = 16;
    localparam int ACC_W = 50;

    // operation codes
    localparam logic [1:0] OP_FEEDBACK = 2'd0;
    localparam logic [1:0] OP_CONTROL  = 2'd1;
    localparam logic [1:0] OP_FRAME    = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_FEEDBACK = 2'd0;
    localparam logic [1:0] KIND_PID      = 2'd1;
    localparam logic [1:0] KIND_FRAME    = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_GAIN_P         = 3'd0;
    localparam logic [2:0] CFG_GAIN_I         = 3'd1;
    localparam logic [2:0] CFG_GAIN_D         = 3'd2;
    localparam logic [2:0] CFG_INTEGRAL_LIMIT = 3'd3;
    localparam logic [2:0] CFG_OUTPUT_LIMIT   = 3'd4;

    typedef struct packed {
        logic [1:0]         operation;
        logic [10:0]        frame_id;
        logic [12:0]        rotor_angle;
        logic signed [15:0] rotor_speed;
        logic [1:0]         motor_index;
        logic signed [15:0] target_speed;
    } mfsp_in_t;

    typedef struct packed {
        logic [1:0]         result_kind;
        logic [1:0]         result_motor;
        logic signed [31:0] turn_ticks;
        logic signed [15:0] drive_current;
        logic [63:0]        current_frame;
    } mfsp_out_t;

    typedef struct packed {
        logic [23:0]        gain_p;
        logic [23:0]        gain_i;
        logic [23:0]        gain_d;
        logic [22:0]        integral_limit;
        logic [14:0]        output_limit;
        logic signed [15:0] target_speed;
        logic signed [15:0] latest_speed;
        logic signed [23:0] error_sum;
        logic signed [16:0] previous_error;
    } mfsp_pid_in_t;

    typedef struct packed {
        logic signed [16:0] error;
        logic signed [23:0] error_sum;
        logic signed [15:0] current;
    } mfsp_pid_out_t;

endpackage

// File: design/mfsp_track.sv
module mfsp_track
    import mfsp_pkg::*;
(
    input  logic [12:0] angle,
    input  logic [12:0] previous_angle,
    input  logic        seen,
    input  logic [31:0] ticks,
    output logic [31:0] ticks_next
);

    logic signed [14:0] raw_delta;
    logic signed [14:0] delta;

    always_comb
    begin
        // first sight of a motor counts as no movement
        if (seen)
        begin
            raw_delta = signed'({2'b00, angle}) - signed'({2'b00, previous_angle});
        end
        else
        begin
            raw_delta = '0;
        end

        // shortest way round the encoder circle; exactly half a turn stays as is
        if (raw_delta > HALF_TURN)
        begin
            delta = raw_delta - FULL_TURN;
        end
        else if (raw_delta < -HALF_TURN)
        begin
            delta = raw_delta + FULL_TURN;
        end
        else
        begin
            delta = raw_delta;
        end
    end

    assign ticks_next = ticks + 32'(delta);

endmodule

// File: design/mfsp_pid.sv
module mfsp_pid
    import mfsp_pkg::*;
(
    input  mfsp_pid_in_t  pid_in,
    output mfsp_pid_out_t pid_out
);

    logic signed [16:0]      err;
    logic signed [24:0]      sum_raw;
    logic signed [24:0]      lim_i;
    logic signed [23:0]      sum_cl;
    logic signed [17:0]      diff;
    logic signed [24:0]      gp;
    logic signed [24:0]      gi;
    logic signed [24:0]      gd;
    logic signed [41:0]      prod_p;
    logic signed [48:0]      prod_i;
    logic signed [42:0]      prod_d;
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] shifted;
    logic signed [ACC_W-1:0] toward_zero;
    logic signed [ACC_W-1:0] res;
    logic signed [ACC_W-1:0] lim_o;
    logic                    round_up;

    always_comb
    begin
        err     = 17'(pid_in.target_speed) - 17'(pid_in.latest_speed);
        sum_raw = 25'(pid_in.error_sum) + 25'(err);
        lim_i   = signed'({2'b00, pid_in.integral_limit});

        // anti-windup clamp on the integrator
        if (sum_raw > lim_i)
        begin
            sum_cl = 24'(lim_i);
        end
        else if (sum_raw < -lim_i)
        begin
            sum_cl = 24'(-lim_i);
        end
        else
        begin
            sum_cl = 24'(sum_raw);
        end

        diff = 18'(err) - 18'(pid_in.previous_error);

        gp = signed'({1'b0, pid_in.gain_p});
        gi = signed'({1'b0, pid_in.gain_i});
        gd = signed'({1'b0, pid_in.gain_d});

        prod_p = gp * err;
        prod_i = gi * sum_cl;
        prod_d = gd * diff;

        acc = ACC_W'(prod_p) + ACC_W'(prod_i) + ACC_W'(prod_d);

        // drop the fraction, rounding negative values toward zero
        shifted     = acc >>> GAIN_FRACTION_BITS;
        round_up    = acc[ACC_W-1] && (|acc[GAIN_FRACTION_BITS-1:0]);
        toward_zero = shifted + signed'(ACC_W'(round_up));

        lim_o = signed'(ACC_W'(pid_in.output_limit));
        if (toward_zero > lim_o)
        begin
            res = lim_o;
        end
        else if (toward_zero < -lim_o)
        begin
            res = -lim_o;
        end
        else
        begin
            res = toward_zero;
        end

        pid_out.error     = err;
        pid_out.error_sum = sum_cl;
        pid_out.current   = 16'(res);
    end

endmodule

// File: design/motor_feedback_speed_pid_core.sv
// Four-motor speed controller with multi-turn rotor tracking. Each input beat is one
// of three operations: a feedback frame (ids 0x201 to 0x204) that stores the motor's
// speed and folds the rotor-angle change into a wrapping 32-bit tick count, a control
// beat that runs the PID of one motor, or a send beat that packs the four current
// commands big-endian into a 64-bit frame (motor 0 in the top 16 bits). Feedback with a
// foreign id and operation code 3 give no output beat and change nothing. Gains are
// unsigned Q8.16; the PID sum is truncated toward zero after the shift and clamped to
// plus or minus output_limit, the integrator to plus or minus integral_limit.
// Throughput is one beat per cycle while nothing stalls. A beat lands in an input
// register, then the per-motor state read, the angle tracker and the three gain
// multiplies run combinationally into the result and state registers, so the
// next beat already sees the updated state. Out stall holds the result register and,
// once the input register is also full, backs up into in_stall. Configuration writes
// take effect at the next edge and belong to times when no beat is in flight.
module motor_feedback_speed_pid_core
    import mfsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        cfg_write_en,
    input  logic [2:0]  cfg_index,
    input  logic [23:0] cfg_data,

    input  logic        in_valid,
    output logic        in_stall,
    input  mfsp_in_t    in_data,

    output logic        out_valid,
    input  logic        out_stall,
    output mfsp_out_t   out_data
);

    // configuration registers
    logic [23:0] gain_p_reg;
    logic [23:0] gain_i_reg;
    logic [23:0] gain_d_reg;
    logic [22:0] integral_limit_reg;
    logic [14:0] output_limit_reg;

    // per-motor state
    logic               seen_reg       [SLOT_COUNT];
    logic [12:0]        prev_angle_reg [SLOT_COUNT];
    logic [31:0]        tick_reg       [SLOT_COUNT];
    logic signed [15:0] speed_reg      [SLOT_COUNT];
    logic signed [23:0] esum_reg       [SLOT_COUNT];
    logic signed [16:0] perr_reg       [SLOT_COUNT];
    logic signed [15:0] cmd_reg        [SLOT_COUNT];

    // pipeline registers
    logic      in_valid_reg;
    mfsp_in_t  in_data_reg;
    logic      out_valid_reg;
    mfsp_out_t out_data_reg;
    mfsp_out_t out_data_next;

    // decode of the registered beat
    logic          is_fb;
    logic          is_pid;
    logic          is_frame;
    logic          has_result;
    logic          advance;
    logic [1:0]    fb_motor;
    logic [1:0]    sel;
    logic [31:0]   ticks_next;
    mfsp_pid_in_t  pid_in;
    mfsp_pid_out_t pid_out;
    logic [63:0]   frame;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_p_reg         <= 24'd524288;
            gain_i_reg         <= 24'd6554;
            gain_d_reg         <= 24'd0;
            integral_limit_reg <= 23'd5000;
            output_limit_reg   <= 15'd16384;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                CFG_GAIN_P:         gain_p_reg         <= cfg_data;
                CFG_GAIN_I:         gain_i_reg         <= cfg_data;
                CFG_GAIN_D:         gain_d_reg         <= cfg_data;
                CFG_INTEGRAL_LIMIT: integral_limit_reg <= cfg_data[22:0];
                CFG_OUTPUT_LIMIT:   output_limit_reg   <= cfg_data[14:0];
                default:            ;
            endcase
        end
    end

    // only the ids owned by a configured motor count as feedback
    assign fb_motor = 2'(in_data_reg.frame_id - ID_BASE);
    assign is_fb    = (in_data_reg.operation == OP_FEEDBACK)
                      && (in_data_reg.frame_id >= ID_BASE)
                      && (in_data_reg.frame_id < ID_END);
    assign is_pid   = (in_data_reg.operation == OP_CONTROL)
                      && ({1'b0, in_data_reg.motor_index} < 3'(MOTOR_COUNT));
    assign is_frame = (in_data_reg.operation == OP_FRAME);
    assign has_result = is_fb || is_pid || is_frame;

    // at most one motor slot is touched per beat
    assign sel = is_fb ? fb_motor : in_data_reg.motor_index;

    // beats with no result retire even while the output is held
    assign advance  = in_valid_reg && (!has_result || !out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !advance;

    mfsp_track u_track (
        .angle          (in_data_reg.rotor_angle),
        .previous_angle (prev_angle_reg[sel]),
        .seen           (seen_reg[sel]),
        .ticks          (tick_reg[sel]),
        .ticks_next     (ticks_next)
    );

    always_comb
    begin
        pid_in.gain_p         = gain_p_reg;
        pid_in.gain_i         = gain_i_reg;
        pid_in.gain_d         = gain_d_reg;
        pid_in.integral_limit = integral_limit_reg;
        pid_in.output_limit   = output_limit_reg;
        pid_in.target_speed   = in_data_reg.target_speed;
        pid_in.latest_speed   = speed_reg[sel];
        pid_in.error_sum      = esum_reg[sel];
        pid_in.previous_error = perr_reg[sel];
    end

    mfsp_pid u_pid (
        .pid_in  (pid_in),
        .pid_out (pid_out)
    );

    // motor 0 goes out first, unused slots pack as zero
    always_comb
    begin
        frame = '0;
        for (int m = 0; m < SLOT_COUNT; m++)
        begin
            if (m < MOTOR_COUNT)
            begin
                frame[(SLOT_COUNT-1-m)*16 +: 16] = cmd_reg[m];
            end
        end
    end

    always_comb
    begin
        out_data_next = '0;
        if (is_fb)
        begin
            out_data_next.result_kind  = KIND_FEEDBACK;
            out_data_next.result_motor = sel;
            out_data_next.turn_ticks   = ticks_next;
        end
        else if (is_pid)
        begin
            out_data_next.result_kind   = KIND_PID;
            out_data_next.result_motor  = sel;
            out_data_next.drive_current = pid_out.current;
        end
        else
        begin
            out_data_next.result_kind   = KIND_FRAME;
            out_data_next.current_frame = frame;
        end
    end

    // per-motor state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int m = 0; m < SLOT_COUNT; m++)
            begin
                seen_reg[m]       <= 1'b0;
                prev_angle_reg[m] <= '0;
                tick_reg[m]       <= '0;
                speed_reg[m]      <= '0;
                esum_reg[m]       <= '0;
                perr_reg[m]       <= '0;
                cmd_reg[m]        <= '0;
            end
        end
        else if (advance)
        begin
            if (is_fb)
            begin
                seen_reg[sel]       <= 1'b1;
                prev_angle_reg[sel] <= in_data_reg.rotor_angle;
                tick_reg[sel]       <= ticks_next;
                speed_reg[sel]      <= in_data_reg.rotor_speed;
            end
            if (is_pid)
            begin
                esum_reg[sel] <= pid_out.error_sum;
                perr_reg[sel] <= pid_out.error;
                cmd_reg[sel]  <= pid_out.current;
            end
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            in_data_reg <= in_data;
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && has_result)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// File: dv/motor_feedback_speed_pid_core_tb.sv
`timescale 1ns / 100ps

// checks the four-motor speed loop against a cycle-free prediction of every result beat
module motor_feedback_speed_pid_core_tb;
    import mfsp_pkg::*;

    // operation code that the block must swallow without a trace
    localparam logic [1:0] OP_UNUSED = 2'd3;

    localparam int CYCLE_LIMIT   = 3_000_000;
    localparam int RANDOM_BEATS  = 260;     // per register setting, five settings
    localparam int GAPLESS_BEATS = 40;      // opening stretch of each setting with no idling
    localparam int SETTLE_CYCLES = 8;       // input and result registers plus margin
    localparam int SQUEEZE_HOLD  = 120;     // long receiver hold-off
    localparam int WIND_TAIL     = 16;      // beats sent after the tick count went through zero
    localparam int IN_W          = $bits(mfsp_in_t);

    // ------------------------------------------------------------------
    // prediction of the block: per-motor state, registers, expected beats
    // ------------------------------------------------------------------
    class speed_loop_tracker;
        logic [23:0] kp;
        logic [23:0] ki;
        logic [23:0] kd;
        logic [22:0] integ_lim;
        logic [14:0] out_lim;
        bit          seen [SLOT_COUNT];
        logic [12:0] prior_angle [SLOT_COUNT];
        logic [31:0] ticks [SLOT_COUNT];
        int          rpm [SLOT_COUNT];
        int          err_sum [SLOT_COUNT];
        int          last_err [SLOT_COUNT];
        logic [15:0] command [SLOT_COUNT];
        mfsp_out_t   pending_results [$];
        int          mismatches;

        function new();
            kp         = 24'd524288;
            ki         = 24'd6554;
            kd         = 24'd0;
            integ_lim  = 23'd5000;
            out_lim    = 15'd16384;
            mismatches = 0;
            for (int m = 0; m < SLOT_COUNT; m++)
            begin
                seen[m]        = 1'b0;
                prior_angle[m] = '0;
                ticks[m]       = '0;
                rpm[m]         = 0;
                err_sum[m]     = 0;
                last_err[m]    = 0;
                command[m]     = '0;
            end
        endfunction

        function void write_register(logic [2:0] index, logic [23:0] value);
            case (index)
                CFG_GAIN_P:         kp = value;
                CFG_GAIN_I:         ki = value;
                CFG_GAIN_D:         kd = value;
                CFG_INTEGRAL_LIMIT: integ_lim = value[22:0];
                CFG_OUTPUT_LIMIT:   out_lim = value[14:0];
                default: ;
            endcase
        endfunction

        function longint clamp_sym(longint v, longint lim);
            if (v > lim)
                return lim;
            if (v < -lim)
                return -lim;
            return v;
        endfunction

        // one accepted input beat: update state, queue the result it causes
        function void take_beat(mfsp_in_t b);
            mfsp_out_t r;
            int        m;
            int        delta;
            longint    err;
            longint    total;
            longint    acc;
            longint    drive;
            r = '0;
            case (b.operation)
                OP_FEEDBACK:
                begin
                    if (b.frame_id < ID_BASE || b.frame_id >= ID_END)
                        return;
                    m = int'(b.frame_id - ID_BASE);
                    rpm[m] = int'($signed(b.rotor_speed));
                    // first sight of a motor counts as no movement
                    if (!seen[m])
                    begin
                        prior_angle[m] = b.rotor_angle;
                        seen[m]        = 1'b1;
                    end
                    delta = int'(b.rotor_angle) - int'(prior_angle[m]);
                    if (delta > int'(HALF_TURN))
                        delta -= int'(FULL_TURN);
                    else if (delta < -int'(HALF_TURN))
                        delta += int'(FULL_TURN);
                    ticks[m]       = ticks[m] + 32'(delta);
                    prior_angle[m] = b.rotor_angle;
                    r.result_kind  = KIND_FEEDBACK;
                    r.result_motor = 2'(m);
                    r.turn_ticks   = ticks[m];
                end
                OP_CONTROL:
                begin
                    m = int'(b.motor_index);
                    if (m >= MOTOR_COUNT)
                        return;
                    err   = longint'($signed(b.target_speed)) - longint'(rpm[m]);
                    total = clamp_sym(longint'(err_sum[m]) + err, longint'(integ_lim));
                    err_sum[m] = int'(total);
                    acc = longint'(kp) * err + longint'(ki) * total
                        + longint'(kd) * (err - longint'(last_err[m]));
                    last_err[m] = int'(err);
                    // drop the fraction toward zero
                    if (acc < 0)
                        drive = -((-acc) >>> GAIN_FRACTION_BITS);
                    else
                        drive = acc >>> GAIN_FRACTION_BITS;
                    drive = clamp_sym(drive, longint'(out_lim));
                    command[m] = 16'(drive);
                    r.result_kind   = KIND_PID;
                    r.result_motor  = 2'(m);
                    r.drive_current = command[m];
                end
                OP_FRAME:
                begin
                    r.result_kind   = KIND_FRAME;
                    r.current_frame = {command[0], command[1], command[2], command[3]};
                end
                default:
                    return;
            endcase
            pending_results.push_back(r);
        endfunction

        function void check_field(string name, logic [63:0] want, logic [63:0] got);
            if (got !== want)
            begin
                mismatches++;
                $display("%0t: %s expected %h got %h", $time, name, want, got);
            end
        endfunction

        function void check_result(mfsp_out_t got);
            mfsp_out_t want;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                $display("%0t: result beat with none expected, got %h", $time, got);
                return;
            end
            want = pending_results.pop_front();
            check_field("result_kind", want.result_kind, got.result_kind);
            check_field("result_motor", want.result_motor, got.result_motor);
            check_field("turn_ticks", want.turn_ticks, got.turn_ticks);
            check_field("drive_current", want.drive_current, got.drive_current);
            check_field("current_frame", want.current_frame, got.current_frame);
        endfunction

        function int outstanding();
            return pending_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------
    // block under test
    // ------------------------------------------------------------------
    logic        clk;
    logic        rst_n;
    logic        cfg_write_en;
    logic [2:0]  cfg_index;
    logic [23:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    mfsp_in_t    in_data;
    logic        out_valid;
    logic        out_stall;
    mfsp_out_t   out_data;

    speed_loop_tracker tracker;

    int unsigned cycle_count = 0;
    bit          rx_jitter   = 1'b1;   // receiver stalls at random while set
    bit          squeeze_req = 1'b0;   // asks the receiver for one long hold-off
    int          hold_left   = 0;
    int          run_left    = 0;
    bit          run_stalled = 1'b0;

    motor_feedback_speed_pid_core dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_data      (in_data),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_data     (out_data)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("motor_feedback_speed_pid_core: mismatch");
            $finish;
        end
    end

    // receiver: runs of ready and stalled cycles, mostly short, now and then long;
    // a squeeze request holds the output off long enough to back up the input side
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (squeeze_req)
        begin
            squeeze_req = 1'b0;
            hold_left   = SQUEEZE_HOLD;
            out_stall <= 1'b1;
        end
        else if (!rx_jitter)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (run_left == 0)
            begin
                run_stalled = ($urandom_range(0, 99) < 35);
                if (!run_stalled)
                    run_left = $urandom_range(1, 24);
                else if ($urandom_range(0, 99) < 90)
                    run_left = $urandom_range(1, 3);
                else
                    run_left = $urandom_range(10, 40);
            end
            run_left--;
            out_stall <= run_stalled;
        end
    end

    // every output beat taken at an edge is checked against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_result(out_data);
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // offer one beat and hold it until the block takes it
    task automatic send_beat(input mfsp_in_t beat);
        in_valid <= 1'b1;
        in_data  <= beat;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        tracker.take_beat(beat);
    endtask

    task automatic pause(input int cycles);
        if (cycles > 0)
        begin
            in_valid <= 1'b0;
            repeat (cycles) @(posedge clk);
        end
    endtask

    // drain everything, then let beats that cause no result clear the pipeline
    task automatic settle();
        in_valid <= 1'b0;
        while (tracker.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(input logic [2:0] index, input logic [23:0] value);
        cfg_write_en <= 1'b1;
        cfg_index    <= index;
        cfg_data     <= value;
        @(posedge clk);
        tracker.write_register(index, value);
    endtask

    task automatic load_settings(input logic [23:0] p, input logic [23:0] i,
                                 input logic [23:0] d, input logic [23:0] il,
                                 input logic [23:0] ol);
        write_register(CFG_GAIN_P, p);
        write_register(CFG_GAIN_I, i);
        write_register(CFG_GAIN_D, d);
        write_register(CFG_INTEGRAL_LIMIT, il);
        write_register(CFG_OUTPUT_LIMIT, ol);
        cfg_write_en <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // beat builders
    // ------------------------------------------------------------------
    function automatic mfsp_in_t feedback_beat(input logic [10:0] id,
                                               input logic [12:0] angle,
                                               input logic [15:0] speed);
        mfsp_in_t b;
        b = '0;
        b.operation   = OP_FEEDBACK;
        b.frame_id    = id;
        b.rotor_angle = angle;
        b.rotor_speed = speed;
        return b;
    endfunction

    function automatic mfsp_in_t control_beat(input logic [1:0] motor,
                                              input logic [15:0] target);
        mfsp_in_t b;
        b = '0;
        b.operation    = OP_CONTROL;
        b.motor_index  = motor;
        b.target_speed = target;
        return b;
    endfunction

    // unused fields all ones, so they must not leak into anything
    function automatic mfsp_in_t plain_beat(input logic [1:0] op);
        mfsp_in_t b;
        b = '1;
        b.operation = op;
        return b;
    endfunction

    // half the time a speed near zero, so the loop works below the clamps
    function automatic logic [15:0] pick_rpm();
        if ($urandom_range(0, 1) == 1)
            return 16'($urandom_range(0, 4000)) - 16'd2000;
        return 16'($urandom);
    endfunction

    function automatic mfsp_in_t random_beat();
        mfsp_in_t b;
        int       r;
        b = IN_W'({$urandom, $urandom});
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            b.operation = OP_FEEDBACK;
            // mostly motor ids, the rest any id at all
            if ($urandom_range(0, 99) < 88)
                b.frame_id = ID_BASE + 11'($urandom_range(0, MOTOR_COUNT - 1));
            if ($urandom_range(0, 1) == 1)
                b.rotor_speed = pick_rpm();
        end
        else if (r < 80)
        begin
            b.operation = OP_CONTROL;
            if ($urandom_range(0, 1) == 1)
                b.target_speed = pick_rpm();
        end
        else if (r < 96)
            b.operation = OP_FRAME;
        else
            b.operation = OP_UNUSED;
        return b;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic random_run(input int count);
        for (int n = 0; n < count; n++)
        begin
            send_beat(random_beat());
            if (n >= GAPLESS_BEATS)
                pause(pick_gap());
        end
    endtask

    // turn the last motor toward zero by 4095 ticks per beat until its tick count
    // goes through zero, wrapping the 32-bit total, then a few beats more
    task automatic wind_motor();
        logic [31:0] prior_ticks;
        logic [12:0] angle;
        logic [12:0] step;
        bit          crossed;
        int          tail;
        angle   = tracker.prior_angle[MOTOR_COUNT - 1];
        // a negative count winds forward, anything else backward
        step    = tracker.ticks[MOTOR_COUNT - 1][31] ? 13'd4095 : 13'd4097;
        crossed = 1'b0;
        tail    = 0;
        while (tail < WIND_TAIL)
        begin
            prior_ticks = tracker.ticks[MOTOR_COUNT - 1];
            angle = angle + step;
            send_beat(feedback_beat(ID_BASE + 11'(MOTOR_COUNT - 1), angle, 16'($urandom)));
            if (prior_ticks[31] != tracker.ticks[MOTOR_COUNT - 1][31])
                crossed = 1'b1;
            if (crossed)
                tail++;
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        tracker = new();
        rst_n        <= 1'b0;
        cfg_write_en <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        in_valid     <= 1'b0;
        in_data      <= '0;
        out_stall    <= 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed beats under the reset register values
        send_beat(plain_beat(OP_UNUSED));
        // motor 0: first sight, then half-turn steps both ways and wraps
        send_beat(feedback_beat(ID_BASE, 13'd0, 16'h7FFF));
        send_beat(feedback_beat(ID_BASE, 13'd4096, 16'h8000));
        send_beat(feedback_beat(ID_BASE, 13'd0, 16'h8000));
        send_beat(feedback_beat(ID_BASE, 13'd4097, 16'h8000));
        send_beat(feedback_beat(ID_BASE, 13'd0, 16'h8000));
        send_beat(feedback_beat(ID_BASE, 13'd8191, 16'h8000));
        send_beat(feedback_beat(ID_BASE + 11'd1, 13'd8191, 16'h0000));
        send_beat(feedback_beat(ID_BASE + 11'd2, 13'h0AAA, 16'hFFFF));
        send_beat(feedback_beat(ID_BASE + 11'd3, 13'h1555, 16'h0001));
        // ids just outside the motor window and at the ends of the id range
        send_beat(feedback_beat(ID_BASE - 11'd1, 13'd8191, 16'h7FFF));
        send_beat(feedback_beat(ID_END, 13'd8191, 16'h7FFF));
        send_beat(feedback_beat(11'd0, 13'd8191, 16'h7FFF));
        send_beat(feedback_beat(11'h7FF, 13'd8191, 16'h7FFF));
        // wide errors both ways across the motors, integrator pushed into its clamp
        send_beat(control_beat(2'd0, 16'h7FFF));
        send_beat(control_beat(2'd1, 16'h8000));
        send_beat(control_beat(2'd2, 16'h7FFF));
        send_beat(control_beat(2'd3, 16'h8000));
        send_beat(control_beat(2'd0, 16'h7FFF));
        send_beat(control_beat(2'd0, 16'h0000));
        send_beat(plain_beat(OP_FRAME));
        send_beat(control_beat(2'd1, 16'h0000));
        send_beat(control_beat(2'd2, 16'h8000));
        send_beat(plain_beat(OP_FRAME));

        // moderate gains with some derivative; long receiver hold-off at the start
        settle();
        load_settings(24'h080000, 24'h00199A, 24'h004000, 24'd5000, 24'd16384);
        squeeze_req = 1'b1;
        random_run(RANDOM_BEATS);

        // everything at its top
        settle();
        load_settings(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'h7FFFFF, 24'h007FFF);
        random_run(RANDOM_BEATS);

        // everything zero: integrator and output pinned at zero
        settle();
        load_settings(24'd0, 24'd0, 24'd0, 24'd0, 24'd0);
        random_run(RANDOM_BEATS);

        // random values in range
        settle();
        load_settings(24'($urandom), 24'($urandom), 24'($urandom),
                      24'($urandom_range(0, 24'h7FFFFF)), 24'($urandom_range(0, 24'h7FFF)));
        random_run(RANDOM_BEATS);

        // mixed extremes: no integral, unit output clamp
        settle();
        load_settings(24'hFFFFFF, 24'd0, 24'hFFFFFF, 24'd0, 24'd1);
        random_run(RANDOM_BEATS);

        // full-rate tick wrap, no idling on either side
        settle();
        rx_jitter = 1'b0;
        wind_motor();
        settle();

        if (tracker.mismatches == 0)
            $display("motor_feedback_speed_pid_core: match");
        else
            $display("motor_feedback_speed_pid_core: mismatch");
        $finish;
    end

endmodule

// File: motor_feedback_speed_pid_core.f
design/mfsp_pkg.sv
design/mfsp_track.sv
design/mfsp_pid.sv
design/motor_feedback_speed_pid_core.sv
dv/motor_feedback_speed_pid_core_tb.sv
